@@ rtl/core/mtg_pkg.sv @@
// Shared opcodes, widths and fixed-point limits of the mesh tangent generator.
package mtg_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam int IDX_W     = 6;
  localparam int COORD_W   = 32;
  localparam int ACC_W     = 48;
  localparam int POS_W     = 3 * COORD_W;
  localparam int TEX_W     = 2 * COORD_W;
  localparam int NRM_W     = 3 * COORD_W;
  localparam int ACCROW_W  = 3 * ACC_W;
  localparam int DIV_STEPS = 80;

  localparam logic signed [63:0] TG_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] TG_MIN   = 64'shFFFF_8000_0000_0000;
  localparam logic signed [64:0] ACC_MAX  = 65'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [64:0] ACC_MIN  = 65'sh1_FFFF_8000_0000_0000;

endpackage

@@ rtl/core/mtg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mesh_tangent_generator_core.sv @@
// Per-vertex tangent generator core: vertex stores, triangle accumulation, read out.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------------------
//  command   | start / busy (start&!busy) | opcode, vertex/second/third_index, pos, tex, norm
//  config    | cfg_valid / cfg_ready      | cfg_data (swap_winding)
//  result    | result_valid (1-cycle)     | tangent_x/y/z, degenerate_seen
//
//  A load completes in the accept cycle; busy stays low, as for a dropped triangle.
//  A triangle holds busy through its accumulate (ending early when its determinant is zero),
//  a read out through its last quotient (ending early when the accumulator is zero): both are
//  dominated by the shared radix-2 divider (three quotients per item); the rest is memory
//  reads, the shared 33x33 multiplier, the square root and the block-normalize shifter
//  (one bit a cycle). An out-of-range read out returns its result in the cycle after
//  acceptance.
//  Reset clears the sequencer, the degenerate flag and swap_winding; the vertex stores
//  are undefined until loaded and get no clearing pass. Results cannot be stalled.
module mesh_tangent_generator_core #(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [5:0]         vertex_index,
  input  logic [5:0]         second_index,
  input  logic [5:0]         third_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  input  logic signed [31:0] norm_x,
  input  logic signed [31:0] norm_y,
  input  logic signed [31:0] norm_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               result_valid,
  output logic signed [31:0] tangent_x,
  output logic signed [31:0] tangent_y,
  output logic signed [31:0] tangent_z,
  output logic               degenerate_seen
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int XW = (AW > 6) ? AW : 6;

  typedef logic [AW-1:0] addr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_T_RD, S_T_DIFF, S_T_DET, S_T_CHK, S_T_NUM, S_DIVIDE, S_T_QUO,
    S_T_ACC_RD, S_T_ACC_WR, S_R_RD, S_R_CAP, S_R_NORM, S_R_DOT, S_R_PROJ,
    S_R_SQ, S_R_SQRT, S_R_DIVSET, S_R_QUO
  } state_t;

  function automatic addr_t to_addr(input logic [5:0] i);
    logic [XW-1:0] e;
    e = XW'(i);
    return e[AW-1:0];
  endfunction

  function automatic logic idx_ok(input logic [5:0] i);
    return 32'(i) < 32'(MAX_VERTICES);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
    if (x > 67'sd2147483647) return 32'sh7FFF_FFFF;
    else if (x < -67'sd2147483648) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic [31:0] b, input logic [31:0] a);
    return sat32(67'($signed(b)) - 67'($signed(a)));
  endfunction

  function automatic logic signed [32:0] tval(input logic [47:0] m, input logic s);
    logic signed [32:0] v;
    v = $signed({3'b000, m[29:0]});
    return s ? -v : v;
  endfunction

  // ---------------------------------------------------------------- registers
  state_t              state;
  logic [1:0]          step;
  logic [1:0]          axis;
  addr_t               corner [3];
  logic                swap_winding;
  logic                deg_flag;

  logic [95:0]         pos_c [3];
  logic [63:0]         tex_c [3];
  logic signed [31:0]  du1, dv1, du2, dv2;
  logic signed [31:0]  dp1 [3];
  logic signed [31:0]  dp2 [3];
  logic signed [66:0]  wacc;
  logic signed [66:0]  det;
  logic signed [63:0]  tg [3];

  logic signed [65:0]  mul_p;
  logic signed [32:0]  mul_a, mul_b;

  logic [79:0]         dq;
  logic [63:0]         rem;
  logic [63:0]         dsr;
  logic [6:0]          div_cnt;
  logic                div_neg;
  logic                div_tri;

  logic [47:0]         vmag [3];
  logic                vsgn [3];
  logic signed [31:0]  nrm [3];
  logic                rd_phase;
  logic signed [31:0]  dval;
  logic [62:0]         sq_x;
  logic [63:0]         sq_root;
  logic [63:0]         sq_bit;

  // ---------------------------------------------------------------- memories
  logic                 load_go;
  addr_t                ld_addr;
  addr_t                pt_raddr, acc_raddr, acc_waddr;
  logic                 acc_we;
  logic [143:0]         acc_wdata, acc_rdata;
  logic [95:0]          pos_rdata, nrm_rdata;
  logic [63:0]          tex_rdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign ld_addr   = to_addr(vertex_index);
  assign load_go   = start && !busy && (opcode == mtg_pkg::OP_LOAD) && idx_ok(vertex_index);

  // Corner reads for the triangle fetch walk a, b, c on consecutive cycles.
  always_comb begin
    unique case (step)
      2'd0:    pt_raddr = corner[0];
      2'd1:    pt_raddr = corner[1];
      default: pt_raddr = corner[2];
    endcase
  end

  assign acc_raddr = (state == S_T_ACC_RD) ? pt_raddr : corner[0];
  assign acc_we    = load_go || (state == S_T_ACC_WR);
  assign acc_waddr = load_go ? ld_addr : pt_raddr;

  mtg_ram #(.WIDTH(mtg_pkg::POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk(clk), .we(load_go), .waddr(ld_addr), .wdata({pos_z, pos_y, pos_x}),
    .raddr(pt_raddr), .rdata(pos_rdata)
  );

  mtg_ram #(.WIDTH(mtg_pkg::TEX_W), .DEPTH(MAX_VERTICES)) u_tex_ram (
    .clk(clk), .we(load_go), .waddr(ld_addr), .wdata({tex_v, tex_u}),
    .raddr(pt_raddr), .rdata(tex_rdata)
  );

  mtg_ram #(.WIDTH(mtg_pkg::NRM_W), .DEPTH(MAX_VERTICES)) u_nrm_ram (
    .clk(clk), .we(load_go), .waddr(ld_addr), .wdata({norm_z, norm_y, norm_x}),
    .raddr(corner[0]), .rdata(nrm_rdata)
  );

  mtg_ram #(.WIDTH(mtg_pkg::ACCROW_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  // ---------------------------------------------------------------- datapath
  logic [1:0]          lane_s, lane_l;
  logic [64:0]         rem_sh;
  logic                div_ge;
  logic [63:0]         rem_nx;
  logic signed [63:0]  tg_val;
  logic signed [64:0]  acc_sum [3];
  logic [47:0]         vmax;
  logic signed [66:0]  sum_now;
  logic signed [66:0]  num_now;
  logic signed [66:0]  rr;
  logic [63:0]         sq_rb;
  logic [30:0]         q_out;
  logic signed [31:0]  q_signed;

  assign lane_s = (step == 2'd3) ? 2'd0 : step;
  assign lane_l = (step == 2'd0) ? 2'd0 : step - 2'd1;

  // Shared multiplier operand select; the product is registered every cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_T_DET: begin
        if (step == 2'd0) begin
          mul_a = 33'(du1);
          mul_b = 33'(dv2);
        end else begin
          mul_a = 33'(dv1);
          mul_b = 33'(du2);
        end
      end
      S_T_NUM: begin
        if (step == 2'd0) begin
          mul_a = 33'(dp1[axis == 2'd3 ? 2'd0 : axis]);
          mul_b = 33'(dv2);
        end else begin
          mul_a = 33'(dp2[axis == 2'd3 ? 2'd0 : axis]);
          mul_b = 33'(dv1);
        end
      end
      S_R_DOT: begin
        mul_a = 33'(nrm[lane_s]);
        mul_b = tval(vmag[lane_s], vsgn[lane_s]);
      end
      S_R_PROJ: begin
        mul_a = 33'(dval);
        mul_b = 33'(nrm[lane_s]);
      end
      S_R_SQ: begin
        mul_a = $signed({3'b000, vmag[lane_s][29:0]});
        mul_b = $signed({3'b000, vmag[lane_s][29:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // One restoring division step.
  assign rem_sh = {rem, dq[79]};
  assign div_ge = (rem_sh >= {1'b0, dsr});
  assign rem_nx = div_ge ? 64'(rem_sh - {1'b0, dsr}) : rem_sh[63:0];

  // Triangle quotient: saturate when the integer part reaches 2^47.
  always_comb begin
    if (dq[79:63] != '0) begin
      tg_val = div_neg ? mtg_pkg::TG_MIN : mtg_pkg::TG_MAX;
    end else if (div_neg) begin
      tg_val = -$signed({1'b0, dq[62:0]});
    end else begin
      tg_val = $signed({1'b0, dq[62:0]});
    end
  end

  // Saturating accumulate of the three tangent lanes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_sum[i] = 65'($signed(acc_rdata[48*i +: 48])) + 65'(tg[i]);
    end
    for (int i = 0; i < 3; i++) begin
      if (acc_sum[i] > mtg_pkg::ACC_MAX) acc_sum[i] = mtg_pkg::ACC_MAX;
      else if (acc_sum[i] < mtg_pkg::ACC_MIN) acc_sum[i] = mtg_pkg::ACC_MIN;
    end
    acc_wdata = load_go ? '0 : {acc_sum[2][47:0], acc_sum[1][47:0], acc_sum[0][47:0]};
  end

  always_comb begin
    vmax = vmag[0];
    if (vmag[1] > vmax) vmax = vmag[1];
    if (vmag[2] > vmax) vmax = vmag[2];
  end

  assign sum_now = wacc + 67'(mul_p);
  assign num_now = wacc - 67'(mul_p);
  assign rr      = 67'(tval(vmag[lane_l], vsgn[lane_l])) - 67'(mul_p >>> 16);
  assign sq_rb   = sq_root + sq_bit;
  assign q_out   = (dq[79:31] != '0) ? 31'h7FFF_FFFF : dq[30:0];
  assign q_signed = div_neg ? -$signed({1'b0, q_out}) : $signed({1'b0, q_out});

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      axis         <= '0;
      deg_flag     <= 1'b0;
      swap_winding <= 1'b0;
      result_valid <= 1'b0;
      div_tri      <= 1'b0;
      rd_phase     <= 1'b0;
    end else begin
      mul_p        <= mul_a * mul_b;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        swap_winding <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          step <= '0;
          axis <= '0;
          if (start) begin
            case (opcode)
              mtg_pkg::OP_TRI: begin
                // Drop the triangle once the flag is set or any corner is out of range.
                if (!deg_flag && idx_ok(vertex_index) && idx_ok(second_index)
                    && idx_ok(third_index)) begin
                  corner[0] <= to_addr(vertex_index);
                  corner[1] <= to_addr(swap_winding ? third_index : second_index);
                  corner[2] <= to_addr(swap_winding ? second_index : third_index);
                  state     <= S_T_RD;
                end
              end
              mtg_pkg::OP_READ: begin
                if (idx_ok(vertex_index)) begin
                  corner[0] <= to_addr(vertex_index);
                  state     <= S_R_RD;
                end else begin
                  tangent_x       <= '0;
                  tangent_y       <= '0;
                  tangent_z       <= '0;
                  degenerate_seen <= deg_flag;
                  result_valid    <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // Fetch corners a, b, c; read data arrives in the cycle after its address.
        S_T_RD: begin
          if (step != 2'd0) begin
            pos_c[lane_l] <= pos_rdata;
            tex_c[lane_l] <= tex_rdata;
          end
          if (step == 2'd3) begin
            step  <= '0;
            state <= S_T_DIFF;
          end else begin
            step <= step + 2'd1;
          end
        end

        S_T_DIFF: begin
          du1 <= sub_sat(tex_c[1][31:0], tex_c[0][31:0]);
          dv1 <= sub_sat(tex_c[1][63:32], tex_c[0][63:32]);
          du2 <= sub_sat(tex_c[2][31:0], tex_c[0][31:0]);
          dv2 <= sub_sat(tex_c[2][63:32], tex_c[0][63:32]);
          for (int i = 0; i < 3; i++) begin
            dp1[i] <= sub_sat(pos_c[1][32*i +: 32], pos_c[0][32*i +: 32]);
            dp2[i] <= sub_sat(pos_c[2][32*i +: 32], pos_c[0][32*i +: 32]);
          end
          state <= S_T_DET;
        end

        S_T_DET: begin
          if (step == 2'd1) begin
            wacc <= 67'(mul_p);
          end
          if (step == 2'd2) begin
            det   <= num_now;
            step  <= '0;
            state <= S_T_CHK;
          end else begin
            step <= step + 2'd1;
          end
        end

        S_T_CHK: begin
          axis <= '0;
          if (det == '0) begin
            deg_flag <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_T_NUM;
          end
        end

        S_T_NUM: begin
          if (step == 2'd1) begin
            wacc <= 67'(mul_p);
          end
          if (step == 2'd2) begin
            dq      <= {(num_now[66] ? 64'(-num_now) : 64'(num_now)), 16'd0};
            dsr     <= det[66] ? 64'(-det) : 64'(det);
            div_neg <= num_now[66] != det[66];
            rem     <= '0;
            div_cnt <= '0;
            div_tri <= 1'b1;
            step    <= '0;
            state   <= S_DIVIDE;
          end else begin
            step <= step + 2'd1;
          end
        end

        S_DIVIDE: begin
          dq      <= {dq[78:0], div_ge};
          rem     <= rem_nx;
          div_cnt <= div_cnt + 7'd1;
          if (div_cnt == 7'(mtg_pkg::DIV_STEPS - 1)) begin
            state <= div_tri ? S_T_QUO : S_R_QUO;
          end
        end

        S_T_QUO: begin
          tg[axis == 2'd3 ? 2'd0 : axis] <= tg_val;
          if (axis == 2'd2) begin
            step  <= '0;
            state <= S_T_ACC_RD;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_T_NUM;
          end
        end

        // Interlocked read-modify-write: each corner's write lands before the next read.
        S_T_ACC_RD: begin
          state <= S_T_ACC_WR;
        end

        S_T_ACC_WR: begin
          if (step == 2'd2) begin
            step  <= '0;
            state <= S_IDLE;
          end else begin
            step  <= step + 2'd1;
            state <= S_T_ACC_RD;
          end
        end

        S_R_RD: begin
          state <= S_R_CAP;
        end

        S_R_CAP: begin
          for (int i = 0; i < 3; i++) begin
            nrm[i]  <= $signed(nrm_rdata[32*i +: 32]);
            vsgn[i] <= acc_rdata[48*i + 47];
            vmag[i] <= acc_rdata[48*i + 47] ? 48'(-acc_rdata[48*i +: 48])
                                            : acc_rdata[48*i +: 48];
          end
          rd_phase <= 1'b0;
          state    <= S_R_NORM;
        end

        // Block normalize: move the largest magnitude into [2^29, 2^30), one bit a cycle.
        S_R_NORM: begin
          step <= '0;
          if (vmax == '0) begin
            tangent_x       <= '0;
            tangent_y       <= '0;
            tangent_z       <= '0;
            degenerate_seen <= deg_flag;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end else if (vmax[47:30] != '0) begin
            for (int i = 0; i < 3; i++) vmag[i] <= vmag[i] >> 1;
          end else if (!vmax[29]) begin
            for (int i = 0; i < 3; i++) vmag[i] <= vmag[i] << 1;
          end else begin
            state <= rd_phase ? S_R_SQ : S_R_DOT;
          end
        end

        S_R_DOT: begin
          if (step == 2'd0) begin
            wacc <= '0;
          end else if (step != 2'd3) begin
            wacc <= sum_now;
          end
          if (step == 2'd3) begin
            dval  <= sat32(sum_now >>> 16);
            step  <= '0;
            state <= S_R_PROJ;
          end else begin
            step <= step + 2'd1;
          end
        end

        // Replace each lane by its rejection from the normal.
        S_R_PROJ: begin
          if (step != 2'd0) begin
            vmag[lane_l] <= rr[66] ? 48'(-rr) : 48'(rr);
            vsgn[lane_l] <= rr[66];
          end
          if (step == 2'd3) begin
            step     <= '0;
            rd_phase <= 1'b1;
            state    <= S_R_NORM;
          end else begin
            step <= step + 2'd1;
          end
        end

        S_R_SQ: begin
          if (step == 2'd0) begin
            wacc <= '0;
          end else if (step != 2'd3) begin
            wacc <= sum_now;
          end
          if (step == 2'd3) begin
            sq_x    <= 63'(sum_now);
            sq_root <= '0;
            sq_bit  <= 64'(1) << 62;
            step    <= '0;
            state   <= S_R_SQRT;
          end else begin
            step <= step + 2'd1;
          end
        end

        // Integer square root, one bit pair a cycle.
        S_R_SQRT: begin
          if ({1'b0, sq_x} >= sq_rb) begin
            sq_x    <= 63'({1'b0, sq_x} - sq_rb);
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            axis  <= '0;
            state <= S_R_DIVSET;
          end
        end

        S_R_DIVSET: begin
          dq      <= {20'd0, vmag[axis == 2'd3 ? 2'd0 : axis][29:0], 30'd0};
          dsr     <= sq_root;
          div_neg <= vsgn[axis == 2'd3 ? 2'd0 : axis]
                     && (vmag[axis == 2'd3 ? 2'd0 : axis] != '0);
          rem     <= '0;
          div_cnt <= '0;
          div_tri <= 1'b0;
          state   <= S_DIVIDE;
        end

        S_R_QUO: begin
          case (axis)
            2'd0:    tangent_x <= q_signed;
            2'd1:    tangent_y <= q_signed;
            default: tangent_z <= q_signed;
          endcase
          if (axis == 2'd2) begin
            degenerate_seen <= deg_flag;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_R_DIVSET;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == mtg_pkg::OP_LOAD)) |=> !busy)
    else $error("load transfer left the sequencer busy");

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    deg_flag |=> deg_flag)
    else $error("degenerate flag dropped without reset");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_R_DOT) |-> ((vmax[47:30] == '0) && vmax[29]))
    else $error("block normalize left largest magnitude out of range");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_R_DIVSET) |-> ((sq_root[63:31] == '0) && (sq_root[30:29] != 2'b00)))
    else $error("vector length out of expected range");
`endif

endmodule

@@ tb/sv/mesh_tangent_generator_core_tb.sv @@
// Self-checking testbench for the mesh tangent generator core, with its own tangent predictor.
module mesh_tangent_generator_core_tb;

  typedef logic signed [127:0] wide_t;
  typedef enum logic [1:0] {K_CMD, K_CFG, K_DRAIN} step_kind_t;

  // One entry of the stimulus plan: a command, a register write or a drain point.
  typedef struct {
    step_kind_t        kind;
    mtg_pkg::opcode_t  op;
    logic [5:0]        a, b, c;
    logic signed [31:0] pos [3];
    logic signed [31:0] tex [2];
    logic signed [31:0] nrm [3];
    logic              winding;
  } plan_step_t;

  typedef struct {
    logic signed [31:0] tx, ty, tz;
    logic               degen;
  } tangent_res_t;

  localparam int NV          = 64;
  localparam int SETTLE      = 450;    // cycles past the last result: covers a triangle
  localparam int STALL_LIMIT = 20000;  // cycles with no transfer before giving up
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = '0;
  logic [5:0] vertex_index = '0, second_index = '0, third_index = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] tex_u = '0, tex_v = '0;
  logic signed [31:0] norm_x = '0, norm_y = '0, norm_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic result_valid;
  logic signed [31:0] tangent_x, tangent_y, tangent_z;
  logic degenerate_seen;

  mesh_tangent_generator_core u_top (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: vertex stores, accumulators, sticky flag, winding register.
  // ---------------------------------------------------------------------------
  logic signed [31:0] vpos [NV][3];
  logic signed [31:0] vtex [NV][2];
  logic signed [31:0] vnrm [NV][3];
  wide_t              vacc [NV][3];
  bit                 degen_flag = 1'b0;
  bit                 swap_wind = 1'b0;

  tangent_res_t tangent_fifo[$];
  plan_step_t   plan[$];
  int           errors = 0;

  function automatic wide_t clamp32(wide_t x);
    if (x > wide_t'(SMAX)) return wide_t'(SMAX);
    if (x < wide_t'(SMIN)) return wide_t'(SMIN);
    return x;
  endfunction

  function automatic wide_t magn(wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  // Q32.32 / Q32.32 -> Q48.16 with truncated magnitude; saturate on a huge integer part.
  function automatic wide_t tangent_quotient(wide_t num, wide_t den);
    wide_t ua, ub, q;
    bit neg;
    ua = magn(num);
    ub = magn(den);
    neg = (num < 0) != (den < 0);
    if (ua / ub >= (128'sd1 <<< 47)) return neg ? -(128'sd1 <<< 47) : (128'sd1 <<< 47) - 1;
    q = (ua <<< 16) / ub;
    return neg ? -q : q;
  endfunction

  // Scale all three magnitudes alike so the largest lands in [2^29, 2^30).
  function automatic bit block_normalize(input wide_t v[3], output wide_t o[3],
                                         output wide_t m[3]);
    wide_t mx;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magn(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (128'sd1 <<< 30)) begin
      mx = mx >>> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >>> 1;
    end
    while (mx < (128'sd1 <<< 29)) begin
      mx = mx <<< 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] <<< 1;
    end
    for (int i = 0; i < 3; i++) o[i] = (v[i] < 0) ? -m[i] : m[i];
    return 1'b1;
  endfunction

  function automatic wide_t int_sqrt(wide_t x);
    wide_t r, bitv;
    r = 0;
    bitv = 128'sd1 <<< 62;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >>> 1) + bitv;
      end else begin
        r = r >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return r;
  endfunction

  function automatic tangent_res_t orthonormal_tangent(int vi);
    tangent_res_t res;
    wide_t acc[3], t[3], r[3], m[3];
    wide_t dot, d, sum, len, q;
    res.tx = '0; res.ty = '0; res.tz = '0;
    res.degen = degen_flag;
    for (int i = 0; i < 3; i++) acc[i] = vacc[vi][i];
    if (!block_normalize(acc, t, m)) return res;
    dot = 0;
    for (int i = 0; i < 3; i++) dot = dot + wide_t'(vnrm[vi][i]) * t[i];
    d = clamp32(dot >>> 16);
    for (int i = 0; i < 3; i++) r[i] = t[i] - ((d * wide_t'(vnrm[vi][i])) >>> 16);
    if (!block_normalize(r, r, m)) return res;
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] <<< 30) / len;
      if (q > wide_t'(SMAX)) q = wide_t'(SMAX);
      if (r[i] < 0) q = -q;
      case (i)
        0: res.tx = q[31:0];
        1: res.ty = q[31:0];
        default: res.tz = q[31:0];
      endcase
    end
    return res;
  endfunction

  task automatic accumulate_triangle(int a, int b, int c);
    wide_t du1, dv1, du2, dv2, det, dp1, dp2, s;
    wide_t tg[3];
    int corner[3];
    du1 = clamp32(wide_t'(vtex[b][0]) - vtex[a][0]);
    dv1 = clamp32(wide_t'(vtex[b][1]) - vtex[a][1]);
    du2 = clamp32(wide_t'(vtex[c][0]) - vtex[a][0]);
    dv2 = clamp32(wide_t'(vtex[c][1]) - vtex[a][1]);
    det = du1 * dv2 - dv1 * du2;
    if (det == 0) begin
      degen_flag = 1'b1;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      dp1 = clamp32(wide_t'(vpos[b][i]) - vpos[a][i]);
      dp2 = clamp32(wide_t'(vpos[c][i]) - vpos[a][i]);
      tg[i] = tangent_quotient(dp1 * dv2 - dp2 * dv1, det);
    end
    corner = '{a, b, c};
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) begin
        s = vacc[corner[k]][i] + tg[i];
        if (s > (128'sd1 <<< 47) - 1) s = (128'sd1 <<< 47) - 1;
        if (s < -(128'sd1 <<< 47)) s = -(128'sd1 <<< 47);
        vacc[corner[k]][i] = s;
      end
  endtask

  // Apply one accepted command to the predictor; queue a tangent for a read out.
  task automatic apply_command(plan_step_t s);
    case (s.op)
      mtg_pkg::OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          vpos[s.a][i] = s.pos[i];
          vnrm[s.a][i] = s.nrm[i];
          vacc[s.a][i] = 0;
        end
        vtex[s.a][0] = s.tex[0];
        vtex[s.a][1] = s.tex[1];
      end
      mtg_pkg::OP_TRI: begin
        if (!degen_flag) begin
          if (swap_wind) accumulate_triangle(int'(s.a), int'(s.c), int'(s.b));
          else accumulate_triangle(int'(s.a), int'(s.b), int'(s.c));
        end
      end
      mtg_pkg::OP_READ: tangent_fifo.push_back(orthonormal_tangent(int'(s.a)));
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus plan builders.
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] span(int half);
    return $signed($urandom_range(2 * half)) - half;
  endfunction

  task automatic plan_load(int idx, logic signed [31:0] p[3], logic signed [31:0] t[2],
                           logic signed [31:0] n[3]);
    plan_step_t s;
    s = '{kind: K_CMD, op: mtg_pkg::OP_LOAD, default: '0};
    s.a = 6'(idx);
    s.b = 6'($urandom); s.c = 6'($urandom);  // unused corners: toggle them anyway
    s.pos = p; s.tex = t; s.nrm = n;
    plan.push_back(s);
  endtask

  task automatic plan_random_load(int idx);
    logic signed [31:0] p[3], t[2], n[3];
    if ($urandom_range(9) == 0) begin
      p = '{$urandom, $urandom, $urandom};
      t = '{$urandom, $urandom};
      n = '{$urandom, $urandom, $urandom};
    end else begin
      p = '{span(1 << 22), span(1 << 22), span(1 << 22)};
      t = '{span(1 << 19), span(1 << 19)};
      n = '{span(1 << 16), span(1 << 16), span(1 << 16)};
    end
    plan_load(idx, p, t, n);
  endtask

  task automatic plan_cmd(mtg_pkg::opcode_t op, int a, int b, int c);
    plan_step_t s;
    s = '{kind: K_CMD, op: mtg_pkg::OP_NONE, default: '0};
    s.op = op; s.a = 6'(a); s.b = 6'(b); s.c = 6'(c);
    // Payload is ignored outside a load; fill it so the bits keep toggling.
    s.pos = '{$urandom, $urandom, $urandom};
    s.tex = '{$urandom, $urandom};
    s.nrm = '{$urandom, $urandom, $urandom};
    plan.push_back(s);
  endtask

  task automatic plan_winding(bit w);
    plan_step_t s;
    s = '{kind: K_DRAIN, op: mtg_pkg::OP_NONE, default: '0};
    plan.push_back(s);
    s.kind = K_CFG; s.winding = w;
    plan.push_back(s);
  endtask

  task automatic plan_random(int count);
    int a, b, c, pick;
    repeat (count) begin
      pick = $urandom_range(99);
      a = $urandom_range(NV - 1);
      if (pick < 15) plan_random_load(a);
      else if (pick < 60) begin
        do b = $urandom_range(NV - 1); while (b == a);
        do c = $urandom_range(NV - 1); while (c == a || c == b);
        plan_cmd(mtg_pkg::OP_TRI, a, b, c);
      end else if (pick < 97) plan_cmd(mtg_pkg::OP_READ, a, $urandom, $urandom);
      else plan_cmd(mtg_pkg::OP_NONE, a, $urandom, $urandom);
    end
  endtask

  task automatic build_plan();
    // Unit-z normals with a tangent along z: rejection vanishes, outputs are zero.
    plan_load(0, '{0, 0, 0},   '{0, 0},   '{0, 0, ONE});
    plan_load(1, '{0, 0, ONE}, '{ONE, 0}, '{0, 0, ONE});
    plan_load(2, '{0, 0, 0},   '{0, ONE}, '{0, 0, ONE});
    plan_cmd(mtg_pkg::OP_TRI, 0, 1, 2);
    plan_cmd(mtg_pkg::OP_READ, 0, 0, 0);
    plan_cmd(mtg_pkg::OP_READ, 1, 0, 0);
    // Field extremes: every difference between vertices 3 and 4 saturates.
    plan_load(3, '{SMAX, SMIN, SMAX}, '{SMIN, SMAX}, '{SMIN, SMAX, 0});
    plan_load(4, '{SMIN, SMAX, SMIN}, '{SMAX, SMIN}, '{ONE, 0, 0});
    plan_load(5, '{32'sh1234_5678, -32'sh0765_4321, 32'sh0000_0001},
              '{ONE, 32'sh0003_0000}, '{0, ONE, 0});
    plan_cmd(mtg_pkg::OP_READ, 3, 63, 63);  // never in a triangle: zero accumulator
    plan_cmd(mtg_pkg::OP_TRI, 3, 4, 5);
    plan_cmd(mtg_pkg::OP_READ, 3, 0, 0);
    plan_cmd(mtg_pkg::OP_READ, 4, 0, 0);
    plan_cmd(mtg_pkg::OP_READ, 5, 0, 0);
    // Reload clears the accumulator; give vertex 1 an x-direction tangent.
    plan_load(1, '{ONE, 0, 0}, '{ONE, 0}, '{0, 0, ONE});
    plan_cmd(mtg_pkg::OP_READ, 1, 0, 0);
    plan_cmd(mtg_pkg::OP_TRI, 1, 2, 0);
    plan_cmd(mtg_pkg::OP_READ, 1, 0, 0);
    plan_cmd(mtg_pkg::OP_READ, 2, 0, 0);
    plan_cmd(mtg_pkg::OP_NONE, 63, 63, 63);
    plan_cmd(mtg_pkg::OP_READ, 0, 0, 0);
    // Fill every vertex so random traffic never touches an unwritten entry.
    for (int i = 0; i < NV; i++) plan_random_load(i);
    plan_winding(1'b1);
    plan_random(300);
    plan_winding(1'b0);
    plan_random(320);
    plan_winding(1'b1);
    // Repeated corner: zero determinant, sets the sticky flag.
    plan_cmd(mtg_pkg::OP_TRI, 7, 7, 9);
    plan_cmd(mtg_pkg::OP_READ, 7, 0, 0);
    plan_random(40);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feed commands and register writes from the plan.
  // ---------------------------------------------------------------------------
  plan_step_t cur;
  int  cmd_xfers = 0;
  int  drain_wait = 0;
  bit  plan_done = 1'b0;

  always @(posedge clk) begin
    bit next_start, next_cfg;
    plan_step_t s;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      next_start = 1'b0;
      next_cfg = cfg_valid;
      // Retire the transfers that complete at this edge.
      if (start && !busy) begin
        apply_command(cur);
        cmd_xfers++;
      end
      if (cfg_valid && cfg_ready) begin
        swap_wind = cfg_data;
        next_cfg = 1'b0;
      end
      if (start && busy) begin
        next_start = 1'b1;  // hold until the core takes it
      end else if (!next_cfg && plan.size() > 0) begin
        s = plan[0];
        case (s.kind)
          K_CMD: begin
            // Skip idling for a stretch in the middle of the run.
            if ((cmd_xfers >= 350 && cmd_xfers < 470) || $urandom_range(99) >= 30) begin
              void'(plan.pop_front());
              cur = s;
              opcode <= s.op;
              vertex_index <= s.a;
              second_index <= s.b;
              third_index <= s.c;
              pos_x <= s.pos[0]; pos_y <= s.pos[1]; pos_z <= s.pos[2];
              tex_u <= s.tex[0]; tex_v <= s.tex[1];
              norm_x <= s.nrm[0]; norm_y <= s.nrm[1]; norm_z <= s.nrm[2];
              next_start = 1'b1;
            end
          end
          K_CFG: begin
            void'(plan.pop_front());
            cfg_data <= s.winding;
            next_cfg = 1'b1;
          end
          default: begin
            // Hold until every tangent is back and a silent triangle has settled.
            if (tangent_fifo.size() == 0) begin
              if (drain_wait >= SETTLE && !busy) begin
                void'(plan.pop_front());
                drain_wait = 0;
              end else begin
                drain_wait++;
              end
            end
          end
        endcase
      end
      start <= next_start;
      cfg_valid <= next_cfg;
      plan_done <= (plan.size() == 0) && !next_start && !next_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result strobe with the oldest predicted tangent.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tangent_res_t want;
    if (!rst && result_valid) begin
      if (tangent_fifo.size() == 0) begin
        $display("%0t: unexpected result %h %h %h flag %b", $time,
                 tangent_x, tangent_y, tangent_z, degenerate_seen);
        errors++;
      end else begin
        want = tangent_fifo.pop_front();
        if (tangent_x !== want.tx) begin
          $display("%0t: tangent_x expected %h actual %h", $time, want.tx, tangent_x);
          errors++;
        end
        if (tangent_y !== want.ty) begin
          $display("%0t: tangent_y expected %h actual %h", $time, want.ty, tangent_y);
          errors++;
        end
        if (tangent_z !== want.tz) begin
          $display("%0t: tangent_z expected %h actual %h", $time, want.tz, tangent_z);
          errors++;
        end
        if (degenerate_seen !== want.degen) begin
          $display("%0t: degenerate_seen expected %b actual %b", $time,
                   want.degen, degenerate_seen);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer of any kind.
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("** mesh_tangent_generator_core: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    build_plan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (!(plan_done && tangent_fifo.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && tangent_fifo.size() == 0) begin
      $display("** mesh_tangent_generator_core: PASSED **");
    end else begin
      $display("** mesh_tangent_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
